// ----- rtl/core/lbph_pkg.sv -----
// Shared types and constants for the LBP block histogram.
package lbph_pkg;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam int CODE_W = 8;
  localparam int LANE_W = 4;
  localparam int SUM_W  = 11;
  localparam int LINE_W = 16;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef logic [3:0] win_idx_t;
  localparam win_idx_t NB_ORDER [8] = '{
    4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3
  };

  typedef struct packed {
    logic                rd;
    logic                clr;
    logic                done;
    logic                mem_en;
    logic [CODE_W-1:0]   row;
    logic [LANE_W-1:0]   lane;
    logic                z0_en;
    logic [LANE_W-1:0]   z0_blk;
    logic                z1_en;
    logic [LANE_W-1:0]   z1_blk;
    logic                rd_ok;
    logic                rd_zero;
  } lbph_op_t;

endpackage

// ----- rtl/core/lbph_front.sv -----
// Front end: pixel position tracking, line store, window, LBP code and bin classification.
module lbph_front
  import lbph_pkg::*;
#(
  parameter int SIZE = 24,
  parameter int GRID = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_kind,
  input  logic [7:0]     in_pixel,
  input  logic [9:0]     in_bin_index,
  output logic           op_valid,
  input  logic           op_ready,
  output lbph_op_t       op
);

  localparam int PW    = $clog2(SIZE);
  localparam int BLK   = SIZE / GRID;
  localparam int HBINS = GRID * GRID * 256;
  localparam logic [PW-1:0] LAST = PW'(SIZE - 1);
  localparam logic [12:0]   HBINS_LIM = 13'(HBINS);

  logic [PW-1:0]     row_r, col_r;
  logic [LINE_W-1:0] line_mem_r [SIZE];
  logic [LINE_W-1:0] line_q_r;

  logic              f1_vld_r, f1_kind_r, f1_done_r, f1_first_r;
  logic [7:0]        f1_px_r;
  logic [PW-1:0]     f1_row_r, f1_col_r;
  logic [9:0]        f1_bin_r;

  logic              f2_vld_r, f2_kind_r, f2_done_r, f2_first_r;
  logic [PW-1:0]     f2_row_r, f2_col_r;
  logic [9:0]        f2_bin_r;
  logic [SUM_W-1:0]  sum_r;

  logic [7:0]        win_r   [9];
  logic [7:0]        win_nxt [9];
  logic [SUM_W-1:0]  sum_nxt;
  logic [7:0]        above2, above1;
  logic [LINE_W-1:0] line_wr;

  logic              accept, f1_move, f2_move;
  logic [CODE_W-1:0] code;

  function automatic logic in_grid(input logic [PW-1:0] coord);
    in_grid = (32'(coord) < GRID * BLK);
  endfunction

  function automatic int blk_of(input logic [PW-1:0] coord);
    int k;
    int b;
    b = 0;
    for (k = 1; k < GRID; k++) begin
      if (32'(coord) >= k * BLK) b = k;
    end
    blk_of = b;
  endfunction

  assign f2_move  = f2_vld_r && op_ready;
  assign f1_move  = f1_vld_r && (!f2_vld_r || op_ready);
  assign in_ready = !f1_vld_r || !f2_vld_r || op_ready;
  assign accept   = in_valid && in_ready;
  assign op_valid = f2_vld_r;

  always_comb begin
    above2 = f1_row_r[0] ? line_q_r[15:8] : line_q_r[7:0];
    above1 = f1_row_r[0] ? line_q_r[7:0] : line_q_r[15:8];
    line_wr = f1_row_r[0] ? {f1_px_r, above1} : {above1, f1_px_r};
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = above2;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = above1;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = f1_px_r;
    sum_nxt = '0;
    for (int k = 0; k < 8; k++) begin
      sum_nxt = sum_nxt + SUM_W'(win_nxt[NB_ORDER[k]]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      f1_vld_r <= accept || (f1_vld_r && !f1_move);
      f2_vld_r <= f1_move || (f2_vld_r && !f2_move);
      if (accept && in_kind == KIND_PIXEL) begin
        if (col_r == LAST) begin
          col_r <= '0;
          row_r <= (row_r == LAST) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (f1_move && f1_kind_r == KIND_PIXEL) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_kind_r  <= in_kind;
      f1_px_r    <= in_pixel;
      f1_bin_r   <= in_bin_index;
      f1_row_r   <= row_r;
      f1_col_r   <= col_r;
      f1_done_r  <= (in_kind == KIND_PIXEL) && row_r == LAST && col_r == LAST;
      f1_first_r <= row_r == '0 && col_r == '0;
      line_q_r   <= line_mem_r[col_r];
    end
    if (f1_move) begin
      f2_kind_r  <= f1_kind_r;
      f2_bin_r   <= f1_bin_r;
      f2_row_r   <= f1_row_r;
      f2_col_r   <= f1_col_r;
      f2_done_r  <= f1_done_r;
      f2_first_r <= f1_first_r;
      sum_r      <= sum_nxt;
    end
    if (f1_move && f1_kind_r == KIND_PIXEL) begin
      line_mem_r[f1_col_r] <= line_wr;
    end
  end

  always_comb begin
    code = '0;
    for (int k = 0; k < 8; k++) begin
      if ((12'(win_r[NB_ORDER[k]]) << 3) + 12'(win_r[NB_ORDER[k]]) > 12'(sum_r)) begin
        code[k] = 1'b1;
      end
    end
  end

  always_comb begin
    logic [PW-1:0] yi, xi;
    op = '0;
    yi = f2_row_r - 1'b1;
    xi = f2_col_r - 1'b1;
    op.done = f2_done_r;
    if (f2_kind_r == KIND_READ) begin
      op.rd      = 1'b1;
      op.rd_ok   = {3'b000, f2_bin_r} < HBINS_LIM;
      op.row     = f2_bin_r[7:0];
      op.lane    = {2'b00, f2_bin_r[9:8]};
      op.rd_zero = f2_bin_r[7:0] == '0;
    end else begin
      op.clr = f2_first_r;
      if ((f2_row_r == '0 || f2_row_r == LAST || f2_col_r == '0 || f2_col_r == LAST)
          && in_grid(f2_row_r) && in_grid(f2_col_r)) begin
        op.z0_en  = 1'b1;
        op.z0_blk = LANE_W'(blk_of(f2_row_r) * GRID + blk_of(f2_col_r));
      end
      if (f2_row_r >= PW'(2) && f2_col_r >= PW'(2) && in_grid(yi) && in_grid(xi)) begin
        if (code == '0) begin
          op.z1_en  = 1'b1;
          op.z1_blk = LANE_W'(blk_of(yi) * GRID + blk_of(xi));
        end else begin
          op.mem_en = 1'b1;
          op.row    = code;
          op.lane   = LANE_W'(blk_of(yi) * GRID + blk_of(xi));
        end
      end
    end
  end

endmodule

// ----- rtl/core/lbph_queue.sv -----
// Short FIFO of classified operations between front and back.
module lbph_queue
  import lbph_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  lbph_op_t wr_op,
  output logic     rd_valid,
  input  logic     rd_ready,
  output lbph_op_t rd_op
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  lbph_op_t       slot_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign wr_ready = cnt_r != (AW + 1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_op    = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_op;
  end

endmodule

// ----- rtl/core/lbph_back.sv -----
// Back end: histogram read-modify-write, code-zero counters, bin reads and result register.
module lbph_back
  import lbph_pkg::*;
#(
  parameter int GRID = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       op_valid,
  output logic       op_ready,
  input  lbph_op_t   op,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_bin_count,
  output logic       out_patch_done
);

  localparam int NB   = GRID * GRID;
  localparam int NBW  = (NB > 1) ? $clog2(NB) : 1;
  localparam int RW   = NB * 8;
  localparam int ROWS = 256;

  logic [RW-1:0]   hist_mem_r [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [7:0]      zcnt_r [NB];

  logic            b_vld_r;
  lbph_op_t        b_op_r;
  logic [RW-1:0]   mem_q_r, fwd_data_r;
  logic            fwd_r, hit_vld_r;
  logic [7:0]      zval_r;

  logic            out_vld_r;
  logic [7:0]      out_cnt_r;
  logic            out_done_r;

  logic            out_take, b_move, a_move, b_wr, fwd_nxt;
  logic [RW-1:0]   src, row_nxt;
  logic [7:0]      lane_val, cnt_nxt;

  assign out_take = !out_vld_r || out_ready;
  assign b_move   = b_vld_r && out_take;
  assign a_move   = op_valid && (!b_vld_r || out_take);
  assign op_ready = !b_vld_r || out_take;
  assign b_wr     = b_move && b_op_r.mem_en;
  assign fwd_nxt  = b_wr && b_op_r.row == op.row && !op.clr;

  always_comb begin
    src = fwd_r ? fwd_data_r : (hit_vld_r ? mem_q_r : '0);
    row_nxt = src;
    for (int i = 0; i < NB; i++) begin
      if (b_op_r.lane[NBW-1:0] == NBW'(i)) begin
        row_nxt[i*8 +: 8] = (src[i*8 +: 8] == CNT_MAX) ? CNT_MAX : src[i*8 +: 8] + 8'd1;
      end
    end
    lane_val = src[int'(b_op_r.lane[NBW-1:0]) * 8 +: 8];
    priority if (!b_op_r.rd || !b_op_r.rd_ok) begin
      cnt_nxt = '0;
    end else if (b_op_r.rd_zero) begin
      cnt_nxt = zval_r;
    end else begin
      cnt_nxt = lane_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      row_vld_r <= '0;
      for (int i = 0; i < NB; i++) begin
        zcnt_r[i] <= '0;
      end
    end else begin
      b_vld_r   <= a_move || (b_vld_r && !b_move);
      out_vld_r <= b_move || (out_vld_r && !out_ready);
      if (a_move && op.clr) begin
        row_vld_r <= '0;
      end else if (b_wr) begin
        row_vld_r[b_op_r.row] <= 1'b1;
      end
      if (a_move) begin
        for (int i = 0; i < NB; i++) begin
          logic [8:0] zs;
          zs = (op.clr ? 9'd0 : 9'(zcnt_r[i]))
             + 9'(op.z0_en && op.z0_blk[NBW-1:0] == NBW'(i))
             + 9'(op.z1_en && op.z1_blk[NBW-1:0] == NBW'(i));
          zcnt_r[i] <= zs[8] ? CNT_MAX : zs[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_op_r     <= op;
      mem_q_r    <= hist_mem_r[op.row];
      hit_vld_r  <= !op.clr && row_vld_r[op.row];
      fwd_r      <= fwd_nxt;
      fwd_data_r <= row_nxt;
      zval_r     <= zcnt_r[op.lane[NBW-1:0]];
    end
    if (b_wr) begin
      hist_mem_r[b_op_r.row] <= row_nxt;
    end
    if (b_move) begin
      out_cnt_r  <= cnt_nxt;
      out_done_r <= b_op_r.done;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_bin_count  = out_cnt_r;
  assign out_patch_done = out_done_r;

endmodule

// ----- rtl/core/lbp_block_histogram.sv -----
// Top level of the LBP block histogram: stream ports, front end, queue and back end.
//
// Input words carry either a patch pixel (tuser 0) or a bin read (tuser 1).
// Pixels arrive in raster order over a SIZE by SIZE patch; the first pixel of
// a patch clears all GRID*GRID histograms of 256 bins. Every input word gives
// exactly one output word: a pixel returns count 0 and raises tlast on the last
// pixel of the patch, a read returns the addressed bin count (0 beyond the last block).
// Throughput is one word per cycle in both directions while out_tready stays high;
// the histogram update is a pipelined read-modify-write on a single-port-write
// memory with forwarding, and code-0 bins live in counters so border and interior
// counts never collide. When the receiver holds out_tready low the output word
// holds, the back end stops, a 4-deep queue fills and then in_tready drops.
// Reset clears positions, window, queue, the row valid bits that stand in for
// a cleared histogram, and the code-0 counters; no clearing pass is needed.
module lbp_block_histogram
  import lbph_pkg::*;
#(
  parameter int SIZE = 24,
  parameter int GRID = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel[7:0], bin_index[17:8]
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bin_count[7:0]
  output logic        out_tlast
);

  lbph_op_t   f_op, q_op;
  logic       f_valid, f_ready, q_valid, q_ready;

  lbph_front #(
    .SIZE (SIZE),
    .GRID (GRID)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_kind      (in_tuser[0]),
    .in_pixel     (in_tdata[7:0]),
    .in_bin_index (in_tdata[17:8]),
    .op_valid     (f_valid),
    .op_ready     (f_ready),
    .op           (f_op)
  );

  lbph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_op    (q_op)
  );

  lbph_back #(
    .GRID (GRID)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (q_valid),
    .op_ready       (q_ready),
    .op             (q_op),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_bin_count  (out_tdata),
    .out_patch_done (out_tlast)
  );

endmodule

// ----- dv/tb_lbp_block_histogram.sv -----
// Self-checking testbench for the LBP block histogram stream block.
`timescale 1ns / 1ps

module tb_lbp_block_histogram;
  import lbph_pkg::*;

  localparam int SIZE     = 24;
  localparam int GRID     = 2;
  localparam int BLK      = SIZE / GRID;
  localparam int NBINS    = GRID * GRID * 256;
  localparam int PATCH_PX = SIZE * SIZE;
  localparam int IDLE_PCT = 28;
  localparam int WD_LIMIT = 2000;
  localparam int HOLD_LEN = 80;
  localparam int NB_CELL [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

  typedef enum int {MODE_NOISE, MODE_BAND, MODE_BINARY, MODE_FLAT} row_mode_t;

  typedef struct packed {
    logic [7:0] count;
    logic       done;
  } bin_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
    logic [9:0] bin_index;
    logic       pinned;
    logic [7:0] count;
    logic       done;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // pixel[7:0], bin_index[17:8]
  logic [0:0]  in_tuser;    // kind[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // bin_count[7:0]
  logic        out_tlast;

  logic [7:0] hist_q [NBINS];
  logic [7:0] line_q [2*SIZE];
  logic [7:0] win_q [9];
  int unsigned pos_row, pos_col;
  int unsigned last_bin;

  bin_word_t bin_words_due [$];
  logic       pinned;
  logic [7:0] pin_count;
  logic       pin_done;
  logic       burst;
  int         mismatches;
  int         words_in;
  int         words_sent;
  int         stall_cycles;
  int         hold_left;
  bit         held;

  stim_row_t dir_rows [20];

  lbp_block_histogram #(.SIZE(SIZE), .GRID(GRID)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void bump_bin(int unsigned y, int unsigned x, int unsigned code);
    int unsigned slot;
    if (y >= GRID * BLK || x >= GRID * BLK) return;
    slot = ((y / BLK) * GRID + x / BLK) * 256 + (code & 255);
    if (hist_q[slot] != 8'hFF) hist_q[slot] = hist_q[slot] + 8'd1;
    last_bin = slot;
  endfunction

  function automatic int unsigned window_code();
    int unsigned sum;
    int unsigned code;
    sum = 0;
    code = 0;
    for (int k = 0; k < 8; k++) sum += win_q[NB_CELL[k]];
    for (int k = 0; k < 8; k++) begin
      if (9 * win_q[NB_CELL[k]] > sum) code |= (1 << k);
    end
    return code;
  endfunction

  function automatic bin_word_t lbp_predict(logic kind, logic [7:0] px, logic [9:0] bi);
    bin_word_t res;
    int unsigned r, c, slot;
    logic [7:0] up2, up1;
    res = '0;
    if (kind == KIND_READ) begin
      res.count = (bi < NBINS) ? hist_q[bi] : 8'd0;
      return res;
    end
    r = pos_row;
    c = pos_col;
    if (r == 0 && c == 0) begin
      for (int i = 0; i < NBINS; i++) hist_q[i] = 8'd0;
    end
    slot = (r & 1) * SIZE + c;
    up2 = line_q[slot];
    up1 = line_q[((r + 1) & 1) * SIZE + c];
    line_q[slot] = px;
    win_q[0] = win_q[1]; win_q[1] = win_q[2]; win_q[2] = up2;
    win_q[3] = win_q[4]; win_q[4] = win_q[5]; win_q[5] = up1;
    win_q[6] = win_q[7]; win_q[7] = win_q[8]; win_q[8] = px;
    if (r == 0 || r == SIZE - 1 || c == 0 || c == SIZE - 1) bump_bin(r, c, 0);
    if (r >= 2 && c >= 2) bump_bin(r - 1, c - 1, window_code());
    if (c + 1 < SIZE) begin
      pos_col = c + 1;
    end else if (r + 1 < SIZE) begin
      pos_col = 0;
      pos_row = r + 1;
    end else begin
      pos_col = 0;
      pos_row = 0;
      res.done = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bin_word_t calc;
    bin_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        calc = lbp_predict(in_tuser[0], in_tdata[7:0], in_tdata[17:8]);
        if (pinned) begin
          calc.count = pin_count;
          calc.done = pin_done;
        end
        bin_words_due = {bin_words_due, calc};
        words_in++;
      end
      if (out_tvalid && out_tready) begin
        if (bin_words_due.size() == 0) begin
          report_mismatch("unexpected word, bin_count", out_tdata, 0);
        end else begin
          want = bin_words_due.pop_front();
          if (out_tdata != want.count) report_mismatch("bin_count", out_tdata, want.count);
          if (out_tlast != want.done) report_mismatch("patch_done", out_tlast, want.done);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WD_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!held && words_in >= 700) begin
        held = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = burst || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(logic kind, logic [7:0] px, logic [9:0] bi,
                           logic pin = 1'b0, logic [7:0] cnt = 8'd0, logic dn = 1'b0);
    while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {6'd0, bi, px};
    pinned = pin;
    pin_count = cnt;
    pin_done = dn;
    words_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (bin_words_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] row_pixel(row_mode_t mode, int base);
    int v;
    case (mode)
      MODE_NOISE: v = $urandom_range(0, 255);
      MODE_BAND: begin
        v = base + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      MODE_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
      default: v = base;
    endcase
    return v[7:0];
  endfunction

  initial begin
    int px_sent;
    int base;
    row_mode_t mode;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    pinned = 1'b0;
    pin_count = '0;
    pin_done = 1'b0;
    burst = 1'b0;
    mismatches = 0;
    words_in = 0;
    words_sent = 0;
    stall_cycles = 0;
    last_bin = 0;
    pos_row = 0;
    pos_col = 0;
    for (int i = 0; i < NBINS; i++) hist_q[i] = 8'd0;
    for (int i = 0; i < 2 * SIZE; i++) line_q[i] = 8'd0;
    for (int i = 0; i < 9; i++) win_q[i] = 8'd0;

    dir_rows = '{
      '{KIND_READ,  8'h00, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_READ,  8'hFF, 10'd1023, 1'b1, 8'd0, 1'b0},
      '{KIND_READ,  8'h5A, 10'd256,  1'b1, 8'd0, 1'b0},
      '{KIND_READ,  8'hA5, 10'd768,  1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h00, 10'd1023, 1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'hFF, 10'h155,  1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'hFF, 10'h2AA,  1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h00, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_READ,  8'h00, 10'd0,    1'b1, 8'd4, 1'b0},
      '{KIND_PIXEL, 8'hAA, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h55, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h01, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h80, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'hFE, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h7F, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'h10, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'hEF, 10'd0,    1'b1, 8'd0, 1'b0},
      '{KIND_READ,  8'hFF, 10'd256,  1'b0, 8'd0, 1'b0},
      '{KIND_READ,  8'h00, 10'h3FF,  1'b0, 8'd0, 1'b0},
      '{KIND_READ,  8'hC3, 10'd0,    1'b0, 8'd0, 1'b0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    px_sent = 0;
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].kind, dir_rows[i].pixel, dir_rows[i].bin_index,
                dir_rows[i].pinned, dir_rows[i].count, dir_rows[i].done);
      if (dir_rows[i].kind == KIND_PIXEL) px_sent++;
    end

    mode = MODE_NOISE;
    base = 0;
    while (px_sent < 2 * PATCH_PX - 3 * SIZE) begin
      burst = (words_sent >= 150 && words_sent < 450);
      if (px_sent % SIZE == 0) begin
        mode = row_mode_t'($urandom_range(0, 3));
        base = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 99) < 5) begin
        send_word(KIND_READ, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 1) ? last_bin[9:0] : 10'($urandom_range(0, 1023)));
      end else begin
        send_word(KIND_PIXEL, row_pixel(mode, base), 10'($urandom_range(0, 1023)));
        px_sent++;
        if (px_sent % PATCH_PX == 0) begin
          drain_all();
          for (int b = 0; b < GRID * GRID; b++) begin
            send_word(KIND_READ, 8'($urandom_range(0, 255)), 10'(b * 256));
          end
          send_word(KIND_READ, 8'($urandom_range(0, 255)), last_bin[9:0]);
        end
      end
    end
    burst = 1'b0;
    for (int b = 0; b < GRID * GRID; b++) begin
      send_word(KIND_READ, 8'($urandom_range(0, 255)),
                10'(b * 256 + $urandom_range(0, 1) * 255));
    end

    drain_all();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- lbp_block_histogram.f -----
rtl/core/lbph_pkg.sv
rtl/core/lbph_front.sv
rtl/core/lbph_queue.sv
rtl/core/lbph_back.sv
rtl/core/lbp_block_histogram.sv
dv/tb_lbp_block_histogram.sv
